/* hw/rtl/bra_pkg.sv */
// Package: constants, types and state codes for the bitmap run allocator.
package bra_pkg;

    localparam int MAP_BITS = 1024;
    localparam int AW       = $clog2(MAP_BITS);
    localparam int PW       = AW + 1;
    localparam int CNTW     = AW + 4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BADREQ  = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;

    typedef enum logic [13:0] {
        S_CLR     = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_A_NF_RD = 14'b00000000000100,
        S_A_NF_EV = 14'b00000000001000,
        S_A_CAND  = 14'b00000000010000,
        S_A_CK_RD = 14'b00000000100000,
        S_A_CK_EV = 14'b00000001000000,
        S_A_MARK  = 14'b00000010000000,
        S_A_FF_RD = 14'b00000100000000,
        S_A_FF_EV = 14'b00001000000000,
        S_F_CK_RD = 14'b00010000000000,
        S_F_CK_EV = 14'b00100000000000,
        S_F_CLR   = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } state_t;

    typedef struct packed {
        logic          bad;
        logic          badfree;
        logic [AW-1:0] amask;
        logic [AW-1:0] color;
        logic [PW-1:0] start;
    } req_t;

endpackage

/* hw/rtl/bra_ram.sv */
// Generic single-port RAM with registered read.
module bra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hw/rtl/bra_decode.sv */
// Request decode: validity checks, alignment mask, color and search start.
module bra_decode (
    input  logic                     kind,
    input  logic [bra_pkg::PW-1:0]   run_length,
    input  logic [bra_pkg::AW-1:0]   align_or_color,
    input  logic [bra_pkg::AW-1:0]   free_offset,
    input  logic [bra_pkg::AW-1:0]   color_count,
    input  logic [bra_pkg::PW-1:0]   last_size,
    input  logic [bra_pkg::AW-1:0]   last_end,
    input  logic [bra_pkg::PW-1:0]   first_free,
    input  logic [bra_pkg::PW-1:0]   used,
    output bra_pkg::req_t            req
);

    logic [bra_pkg::PW-1:0] align;
    logic [bra_pkg::PW-1:0] amask;
    logic                   bad_alloc;
    logic                   bad_free;
    logic [bra_pkg::PW:0]   free_end;

    always_comb
    begin
        if (color_count != '0)
        begin
            align = {1'b0, color_count};
        end
        else if (align_or_color == '0)
        begin
            align = bra_pkg::PW'(1);
        end
        else
        begin
            align = {1'b0, align_or_color};
        end
        amask     = align - bra_pkg::PW'(1);
        bad_alloc = ((align & amask) != '0) || (align >= bra_pkg::PW'(bra_pkg::MAP_BITS))
                    || (run_length == '0) || (run_length > bra_pkg::PW'(bra_pkg::MAP_BITS));
        free_end  = (bra_pkg::PW+1)'(free_offset) + (bra_pkg::PW+1)'(run_length);
        bad_free  = (run_length == '0) || (free_end > (bra_pkg::PW+1)'(bra_pkg::MAP_BITS));

        req.bad     = (kind == bra_pkg::KIND_ALLOC) ? bad_alloc : bad_free;
        req.badfree = used < run_length;
        req.amask   = amask[bra_pkg::AW-1:0];
        req.color   = (color_count != '0) ? (align_or_color & amask[bra_pkg::AW-1:0]) : '0;
        if (run_length < last_size)
        begin
            req.start = first_free;
        end
        else
        begin
            req.start = {1'b0, last_end & ~amask[bra_pkg::AW-1:0]};
        end
    end

endmodule

/* hw/rtl/bitmap_run_allocator.sv */
// Top level: bit-serial sequencer over a 1-bit occupancy RAM.
// After reset the occupancy RAM is cleared, one bit a cycle, with s_tready low;
// config writes are taken throughout.
// Bad requests go straight to the result state. Allocation reads then evaluates
// each scanned bit, steps to each aligned candidate, marks the run bit by bit
// and, if the run began at the first free bit, rescans for the next free bit;
// free checks each bit of the run, then clears it. One transaction in flight; result is registered.
module bitmap_run_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // run_length[10:0], align_or_color[20:11], free_offset[30:21]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // run_offset[9:0], status[11:10], used_bits[22:12]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);

    localparam int AW   = bra_pkg::AW;
    localparam int PW   = bra_pkg::PW;
    localparam int CNTW = bra_pkg::CNTW;
    localparam logic [PW-1:0]   MAPP = PW'(bra_pkg::MAP_BITS);
    localparam logic [CNTW-1:0] MAPC = CNTW'(bra_pkg::MAP_BITS);

    bra_pkg::state_t state_reg, state_next;
    bra_pkg::req_t   req;

    logic [AW-1:0]   cc_reg;
    logic [PW-1:0]   ffm_reg, ffm_next;
    logic [AW-1:0]   lend_reg, lend_next;
    logic [PW-1:0]   lsize_reg, lsize_next;
    logic [PW-1:0]   used_reg, used_next;

    logic [PW-1:0]   len_reg, len_next;
    logic [AW-1:0]   foff_reg, foff_next;
    logic [AW-1:0]   amask_reg, amask_next;
    logic [AW-1:0]   color_reg, color_next;
    logic [PW-1:0]   ptr_reg, ptr_next;
    logic [PW-1:0]   off_reg, off_next;
    logic [PW-1:0]   i_reg, i_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [AW-1:0]   roff_reg, roff_next;
    logic [1:0]      rst_reg, rst_next;

    logic            mv_reg, mv_next;
    logic [23:0]     md_reg, md_next;

    logic            ram_we;
    logic            ram_wdata;
    logic            ram_rdata;

    logic [PW:0]     cand;
    logic [PW-1:0]   cand_off;
    logic [CNTW-1:0] cand_cnt;
    logic [PW:0]     step_off;
    logic [PW-1:0]   i_inc;
    logic [PW:0]     run_end;

    bra_decode u_decode (
        .kind           (s_tuser),
        .run_length     (s_tdata[10:0]),
        .align_or_color (s_tdata[20:11]),
        .free_offset    (s_tdata[30:21]),
        .color_count    (cc_reg),
        .last_size      (lsize_reg),
        .last_end       (lend_reg),
        .first_free     (ffm_reg),
        .used           (used_reg),
        .req            (req)
    );

    bra_ram #(
        .WIDTH (1),
        .DEPTH (bra_pkg::MAP_BITS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ptr_reg[AW-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == bra_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = md_reg;

    always_comb
    begin
        cand     = ((PW+1)'(ptr_reg) + (PW+1)'(amask_reg)) & ~(PW+1)'(amask_reg);
        cand     = cand + (PW+1)'(color_reg);
        cand_off = (cand >= (PW+1)'(bra_pkg::MAP_BITS)) ? '0 : cand[PW-1:0];
        cand_cnt = count_reg + CNTW'(cand) - CNTW'(off_reg);
        i_inc    = i_reg + PW'(1);
        step_off = (PW+1)'(off_reg) + (PW+1)'(i_inc);
        run_end  = (PW+1)'(off_reg) + (PW+1)'(len_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        ffm_next   = ffm_reg;
        lend_next  = lend_reg;
        lsize_next = lsize_reg;
        used_next  = used_reg;
        len_next   = len_reg;
        foff_next  = foff_reg;
        amask_next = amask_reg;
        color_next = color_reg;
        ptr_next   = ptr_reg;
        off_next   = off_reg;
        i_next     = i_reg;
        count_next = count_reg;
        roff_next  = roff_reg;
        rst_next   = rst_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        ram_we     = 1'b0;
        ram_wdata  = 1'b0;

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            bra_pkg::S_CLR:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg + PW'(1);
                if (ptr_reg == MAPP - PW'(1))
                begin
                    state_next = bra_pkg::S_IDLE;
                end
            end
            bra_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    len_next   = s_tdata[10:0];
                    foff_next  = s_tdata[30:21];
                    amask_next = req.amask;
                    color_next = req.color;
                    roff_next  = '0;
                    i_next     = '0;
                    count_next = '0;
                    if (req.bad)
                    begin
                        rst_next   = bra_pkg::ST_BADREQ;
                        state_next = bra_pkg::S_DONE;
                    end
                    else if (s_tuser == bra_pkg::KIND_ALLOC)
                    begin
                        off_next   = req.start;
                        ptr_next   = req.start;
                        state_next = bra_pkg::S_A_NF_RD;
                    end
                    else if (req.badfree)
                    begin
                        rst_next   = bra_pkg::ST_BADFREE;
                        state_next = bra_pkg::S_DONE;
                    end
                    else
                    begin
                        ptr_next   = {1'b0, s_tdata[30:21]};
                        state_next = bra_pkg::S_F_CK_RD;
                    end
                end
            end
            bra_pkg::S_A_NF_RD:
            begin
                state_next = (ptr_reg >= MAPP) ? bra_pkg::S_A_CAND : bra_pkg::S_A_NF_EV;
            end
            bra_pkg::S_A_NF_EV:
            begin
                if (ram_rdata)
                begin
                    ptr_next   = ptr_reg + PW'(1);
                    state_next = bra_pkg::S_A_NF_RD;
                end
                else
                begin
                    state_next = bra_pkg::S_A_CAND;
                end
            end
            bra_pkg::S_A_CAND:
            begin
                if (cand_cnt + CNTW'(len_reg) > MAPC)
                begin
                    rst_next   = bra_pkg::ST_FULL;
                    state_next = bra_pkg::S_DONE;
                end
                else if ((PW+1)'(cand_off) + (PW+1)'(len_reg) > (PW+1)'(bra_pkg::MAP_BITS))
                begin
                    count_next = cand_cnt + MAPC - CNTW'(cand_off);
                    off_next   = '0;
                    ptr_next   = '0;
                    state_next = bra_pkg::S_A_NF_RD;
                end
                else
                begin
                    count_next = cand_cnt;
                    off_next   = cand_off;
                    ptr_next   = cand_off;
                    i_next     = '0;
                    state_next = bra_pkg::S_A_CK_RD;
                end
            end
            bra_pkg::S_A_CK_RD:
            begin
                state_next = bra_pkg::S_A_CK_EV;
            end
            bra_pkg::S_A_CK_EV:
            begin
                if (!ram_rdata)
                begin
                    if (i_inc == len_reg)
                    begin
                        ptr_next   = off_reg;
                        i_next     = '0;
                        state_next = bra_pkg::S_A_MARK;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        ptr_next   = ptr_reg + PW'(1);
                        state_next = bra_pkg::S_A_CK_RD;
                    end
                end
                else
                begin
                    count_next = count_reg + CNTW'(i_inc);
                    off_next   = (step_off >= (PW+1)'(bra_pkg::MAP_BITS)) ? '0 : step_off[PW-1:0];
                    ptr_next   = (step_off >= (PW+1)'(bra_pkg::MAP_BITS)) ? '0 : step_off[PW-1:0];
                    state_next = bra_pkg::S_A_NF_RD;
                end
            end
            bra_pkg::S_A_MARK:
            begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                ptr_next  = ptr_reg + PW'(1);
                i_next    = i_inc;
                if (i_inc == len_reg)
                begin
                    used_next  = used_reg + len_reg;
                    lsize_next = len_reg;
                    lend_next  = (run_end >= (PW+1)'(bra_pkg::MAP_BITS)) ? '0 : run_end[AW-1:0];
                    roff_next  = off_reg[AW-1:0];
                    rst_next   = bra_pkg::ST_OK;
                    if (off_reg == ffm_reg)
                    begin
                        ptr_next   = ffm_reg + len_reg;
                        state_next = bra_pkg::S_A_FF_RD;
                    end
                    else
                    begin
                        state_next = bra_pkg::S_DONE;
                    end
                end
            end
            bra_pkg::S_A_FF_RD:
            begin
                if (ptr_reg >= MAPP)
                begin
                    ffm_next   = MAPP;
                    state_next = bra_pkg::S_DONE;
                end
                else
                begin
                    state_next = bra_pkg::S_A_FF_EV;
                end
            end
            bra_pkg::S_A_FF_EV:
            begin
                if (ram_rdata)
                begin
                    ptr_next   = ptr_reg + PW'(1);
                    state_next = bra_pkg::S_A_FF_RD;
                end
                else
                begin
                    ffm_next   = ptr_reg;
                    state_next = bra_pkg::S_DONE;
                end
            end
            bra_pkg::S_F_CK_RD:
            begin
                state_next = bra_pkg::S_F_CK_EV;
            end
            bra_pkg::S_F_CK_EV:
            begin
                if (!ram_rdata)
                begin
                    rst_next   = bra_pkg::ST_BADFREE;
                    state_next = bra_pkg::S_DONE;
                end
                else if (i_inc == len_reg)
                begin
                    ptr_next   = {1'b0, foff_reg};
                    i_next     = '0;
                    state_next = bra_pkg::S_F_CLR;
                end
                else
                begin
                    i_next     = i_inc;
                    ptr_next   = ptr_reg + PW'(1);
                    state_next = bra_pkg::S_F_CK_RD;
                end
            end
            bra_pkg::S_F_CLR:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg + PW'(1);
                i_next   = i_inc;
                if (i_inc == len_reg)
                begin
                    if ({1'b0, foff_reg} < ffm_reg)
                    begin
                        ffm_next = {1'b0, foff_reg};
                    end
                    used_next  = used_reg - len_reg;
                    rst_next   = bra_pkg::ST_OK;
                    state_next = bra_pkg::S_DONE;
                end
            end
            bra_pkg::S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {1'b0, used_reg, rst_reg, roff_reg};
                    state_next = bra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bra_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bra_pkg::S_CLR;
            cc_reg    <= '0;
            ffm_reg   <= '0;
            lend_reg  <= '0;
            lsize_reg <= '0;
            used_reg  <= '0;
            ptr_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                cc_reg <= cfg_data;
            end
            ffm_reg   <= ffm_next;
            lend_reg  <= lend_next;
            lsize_reg <= lsize_next;
            used_reg  <= used_next;
            ptr_reg   <= ptr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        foff_reg  <= foff_next;
        amask_reg <= amask_next;
        color_reg <= color_next;
        off_reg   <= off_next;
        i_reg     <= i_next;
        count_reg <= count_next;
        roff_reg  <= roff_next;
        rst_reg   <= rst_next;
        md_reg    <= md_next;
    end

endmodule

/* verif/bra_checker.sv */
// Checker: predicts bitmap run allocator results and compares them on the result channel.
`timescale 1ns / 1ps

module bra_checker
    import bra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [10:0] used;
        logic [1:0]  status;
        logic [9:0]  offset;
    } result_t;

    bit          occ [MAP_BITS];
    int unsigned first_free;
    int unsigned run_end;
    int unsigned run_size;
    int unsigned used_bits;
    int unsigned colors;
    result_t     expected_q [$];

    function automatic int unsigned next_free_bit(int unsigned p);
        while (p < MAP_BITS && occ[p])
            p++;
        return p;
    endfunction

    function automatic logic [1:0] alloc_run(int unsigned len, int unsigned field,
                                             output int unsigned off);
        int unsigned align, amask, color, pos, scanned, cand, i;
        off = 0;
        if (colors != 0) begin
            color = field;
            align = colors;
        end
        else begin
            color = 0;
            align = (field == 0) ? 1 : field;
        end
        amask = align - 1;
        if ((align & amask) != 0 || align >= MAP_BITS || len == 0 || len > MAP_BITS)
            return ST_BADREQ;
        color &= amask;
        pos = (len < run_size) ? first_free : (run_end & ~amask);
        scanned = 0;
        forever
        begin
            cand = ((next_free_bit(pos) + amask) & ~amask) + color;
            scanned += cand - pos;
            pos = cand;
            if (pos >= MAP_BITS)
                pos = 0;
            if (scanned + len > MAP_BITS)
                return ST_FULL;
            if (pos + len > MAP_BITS)
            begin
                scanned += MAP_BITS - pos;
                pos = 0;
                continue;
            end
            i = 0;
            while (!occ[pos + i])
            begin
                i++;
                if (i == len)
                begin
                    for (int k = 0; k < len; k++)
                        occ[pos + k] = 1'b1;
                    if (pos == first_free)
                        first_free = next_free_bit(first_free + len);
                    run_end = pos + len;
                    if (run_end >= MAP_BITS)
                        run_end = 0;
                    used_bits += len;
                    run_size = len;
                    off = pos;
                    return ST_OK;
                end
            end
            scanned += i + 1;
            pos += i + 1;
            if (pos >= MAP_BITS)
                pos = 0;
        end
    endfunction

    function automatic logic [1:0] free_run(int unsigned off, int unsigned len);
        if (len == 0 || off + len > MAP_BITS)
            return ST_BADREQ;
        if (used_bits < len)
            return ST_BADFREE;
        for (int k = 0; k < len; k++)
            if (!occ[off + k])
                return ST_BADFREE;
        for (int k = 0; k < len; k++)
            occ[off + k] = 1'b0;
        if (off < first_free)
            first_free = off;
        used_bits -= len;
        return ST_OK;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t     exp_r;
        result_t     got;
        int unsigned off;
        logic [1:0]  st;
        if (!rst_n)
        begin
            foreach (occ[k])
                occ[k] = 1'b0;
            first_free = 0;
            run_end    = 0;
            run_size   = 0;
            used_bits  = 0;
            colors     = 0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                colors = cfg_data;
            if (s_tvalid && s_tready)
            begin
                off = 0;
                if (s_tuser == KIND_ALLOC)
                    st = alloc_run(s_tdata[10:0], s_tdata[20:11], off);
                else
                    st = free_run(s_tdata[30:21], s_tdata[10:0]);
                if (st != ST_OK)
                    off = 0;
                exp_r.offset = off[9:0];
                exp_r.status = st;
                exp_r.used   = used_bits[10:0];
                expected_q.push_back(exp_r);
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[22:0];
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got.offset !== exp_r.offset)
                    begin
                        $display("%0t: run_offset expected %0d actual %0d",
                                 $time, exp_r.offset, got.offset);
                        fail_count++;
                    end
                    if (got.status !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, got.status);
                        fail_count++;
                    end
                    if (got.used !== exp_r.used)
                    begin
                        $display("%0t: used_bits expected %0d actual %0d",
                                 $time, exp_r.used, got.used);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

/* verif/bitmap_run_allocator_tb.sv */
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the run allocator.
`timescale 1ns / 1ps

module bitmap_run_allocator_tb;
    import bra_pkg::*;

    localparam logic KIND_FREE  = ~KIND_ALLOC;
    localparam int   IDLE_LIMIT = 20000;
    localparam int   PHASE_ITEMS = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data = '0;
    int          fail_count;
    int          pending;

    int          sent;
    int          rcvd;
    int          idle_cycles;
    int          last_used;
    logic        kind_q [$];
    int          len_q [$];
    int          run_off [$];
    int          run_len [$];

    always #5 clk = ~clk;

    bitmap_run_allocator u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    bra_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // track transactions, live runs and progress
    always @(posedge clk)
    begin
        logic k;
        int   l;
        if (rst_n)
        begin
            idle_cycles++;
            if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            if (s_tvalid && s_tready)
            begin
                kind_q.push_back(s_tuser);
                len_q.push_back(s_tdata[10:0]);
                sent++;
            end
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                rcvd++;
                last_used = m_tdata[22:12];
                if (kind_q.size() > 0)
                begin
                    k = kind_q.pop_front();
                    l = len_q.pop_front();
                    if (k == KIND_ALLOC && m_tdata[11:10] == ST_OK)
                    begin
                        run_off.push_back(m_tdata[9:0]);
                        run_len.push_back(l);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, one long hold-off
    initial
    begin
        bit held;
        held = 0;
        forever
        begin
            if (!held && sent >= 400)
            begin
                held = 1;
                m_tready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic send(logic kind, int len, int field, int foff, bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, foff[9:0], field[9:0], len[10:0]};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_and_config(logic [9:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (rcvd != sent)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item(logic [9:0] colors, bit no_gap);
        int r, idx, len, field;
        r = $urandom_range(0, 99);
        if (run_off.size() > 0 && r < (last_used > 600 ? 70 : 40))
        begin
            idx = $urandom_range(0, run_off.size() - 1);
            send(KIND_FREE, run_len[idx], $urandom_range(0, 1023), run_off[idx], no_gap);
            run_off.delete(idx);
            run_len.delete(idx);
        end
        else if (r >= 95)
        begin
            send(KIND_FREE, $urandom_range(0, 40), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), no_gap);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 84)
                len = $urandom_range(1, 8);
            else if (r < 96)
                len = $urandom_range(9, 64);
            else if (r < 98)
                len = $urandom_range(65, 1024);
            else
                len = $urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047);
            r = $urandom_range(0, 99);
            if (colors != 0 || r >= 95)
                field = $urandom_range(0, 1023);
            else if (r < 80)
                field = 1 << $urandom_range(0, 4);
            else if (r < 90)
                field = 0;
            else
                field = 1 << $urandom_range(5, 9);
            send(KIND_ALLOC, len, field, $urandom_range(0, 1023), no_gap);
        end
    endtask

    initial
    begin
        logic [9:0] phase_colors [6];
        bit         no_gap;
        phase_colors = '{10'd0, 10'd512, 10'd4, 10'd1023, 10'd1, 10'd8};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        drain_and_config(10'd0);

        // directed corners
        send(KIND_ALLOC, 1, 0, 0);
        send(KIND_FREE, 1, 0, 0);
        send(KIND_ALLOC, 1024, 1, 1023);
        send(KIND_ALLOC, 1, 0, 0);              // map full
        send(KIND_FREE, 1024, 0, 0);
        send(KIND_ALLOC, 0, 0, 0);              // zero length
        send(KIND_ALLOC, 1025, 0, 0);           // longer than map
        send(KIND_ALLOC, 2047, 1023, 1023);
        send(KIND_ALLOC, 4, 3, 0);              // alignment not a power of two
        send(KIND_ALLOC, 4, 512, 0);
        send(KIND_ALLOC, 8, 512, 0);
        send(KIND_ALLOC, 2, 8, 0);
        send(KIND_FREE, 0, 0, 5);               // zero length free
        send(KIND_FREE, 8, 0, 1020);            // free past the end
        send(KIND_FREE, 4, 0, 700);             // free of free bits
        send(KIND_FREE, 100, 0, 0);             // more than in use
        send(KIND_FREE, 4, 0, 0);
        send(KIND_FREE, 8, 0, 512);
        send(KIND_FREE, 2, 0, 8);
        send(KIND_FREE, 4, 1023, 0);            // freeing twice

        foreach (phase_colors[p])
        begin
            drain_and_config(phase_colors[p]);
            if (phase_colors[p] != 0)
            begin
                send(KIND_ALLOC, 3, 1023, 0);
                send(KIND_ALLOC, 5, 1, 0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                no_gap = (n % 100) < 20;
                random_item(phase_colors[p], no_gap);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (rcvd != sent)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bra_pkg.sv
hw/rtl/bra_ram.sv
hw/rtl/bra_decode.sv
hw/rtl/bitmap_run_allocator.sv
verif/bra_checker.sv
verif/bitmap_run_allocator_tb.sv
